// File: hw/rtl/rtst_pkg.sv
// Shared types, constants and codes for the robust trend slope tracker.
package rtst_pkg;

    // Default history length, newest sample at index 0.
    localparam int HISTORY_DEPTH_DEF = 8;

    // Sample values are signed Q15.8, slopes are signed with 16 fractional bits.
    localparam int VALUE_W     = 24;
    localparam int DIFF_W      = VALUE_W + 1;
    localparam int FRAC_SHIFT  = 8;
    localparam int MAG_W       = VALUE_W + FRAC_SHIFT;
    localparam int SLOPE_W     = 34;
    localparam int COUNT_OUT_W = 4;

    // The divider retires this many quotient bits in each cycle.
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = MAG_W / DIV_RADIX_BITS;
    localparam int DIV_STEP_W     = $clog2(DIV_STEPS + 1);

    // Request codes carried in req_type.
    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    // Which rule produced the slope.
    typedef enum logic [1:0] {
        RULE_FEW    = 2'd0,
        RULE_TWO    = 2'd1,
        RULE_CHANGE = 2'd2,
        RULE_RECENT = 2'd3
    } rtst_rule_t;

    typedef struct packed {
        logic                      req_type;
        logic                      sample_found;
        logic signed [VALUE_W-1:0] sample_value;
    } rtst_in_t;

    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        rtst_rule_t                slope_rule;
        logic [COUNT_OUT_W-1:0]    found_count;
    } rtst_out_t;

endpackage

// File: hw/rtl/rtst_div.sv
// Multi-cycle signed divider for (diff * 256) / span, truncating toward zero.
module rtst_div #(
    parameter int DIST_W = $clog2(rtst_pkg::HISTORY_DEPTH_DEF)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [rtst_pkg::DIFF_W-1:0]  diff,
    input  logic        [DIST_W-1:0]            span,
    output logic                                done,
    output logic signed [rtst_pkg::SLOPE_W-1:0] quot
);

    localparam int MAG_W = rtst_pkg::MAG_W;

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [rtst_pkg::DIV_STEP_W-1:0]   step_reg, step_next;
    logic [MAG_W-1:0]                  work_reg, work_next;
    logic [DIST_W-1:0]                 rem_reg, rem_next;
    logic [DIST_W-1:0]                 dist_reg, dist_next;
    logic                              neg_reg, neg_next;

    logic [rtst_pkg::VALUE_W-1:0]      abs_diff;
    logic [MAG_W-1:0]                  w;
    logic [DIST_W-1:0]                 r;
    logic [DIST_W:0]                   t;

    // The difference of two samples never reaches 2^24 in magnitude.
    assign abs_diff = diff[rtst_pkg::DIFF_W-1] ? rtst_pkg::VALUE_W'(-diff)
                                               : rtst_pkg::VALUE_W'(diff);

    // Restoring division: the dividend shifts out of the top of work_reg while
    // the quotient bits shift in at the bottom.
    always_comb
    begin
        w = work_reg;
        r = rem_reg;
        t = '0;
        for (int k = 0; k < rtst_pkg::DIV_RADIX_BITS; k++)
        begin
            t = {r, w[MAG_W-1]};
            w = {w[MAG_W-2:0], 1'b0};
            if (t >= {1'b0, dist_reg})
            begin
                t    = t - {1'b0, dist_reg};
                w[0] = 1'b1;
            end
            r = t[DIST_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dist_next = dist_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = rtst_pkg::DIV_STEP_W'(rtst_pkg::DIV_STEPS);
            work_next = {abs_diff, rtst_pkg::FRAC_SHIFT'(0)};
            rem_next  = '0;
            dist_next = span;
            neg_next  = diff[rtst_pkg::DIFF_W-1];
        end
        else if (busy_reg)
        begin
            work_next = w;
            rem_next  = r;
            step_next = step_reg - 1'b1;
            if (step_reg == rtst_pkg::DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dist_reg <= dist_next;
        neg_reg  <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -rtst_pkg::SLOPE_W'(work_reg) : rtst_pkg::SLOPE_W'(work_reg);

endmodule

// File: hw/rtl/robust_trend_slope_tracker_core.sv
// Top level of the robust trend slope tracker: history, sequencer and result register.
// A restart item gives no result. An update scans the whole history, oldest first, and then
// decides. With two or more found samples it runs the trend division; with more than two it then
// walks the positions toward the newest found sample, with one division per intermediate found
// sample. Each update emits its result once the result register can take it.
// Reset (rst_n low, asynchronous) clears the history to zero and empties the result register.
module robust_trend_slope_tracker_core #(
    parameter int HISTORY_DEPTH = rtst_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  rtst_pkg::rtst_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output rtst_pkg::rtst_out_t result
);

    localparam int IDX_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_RAW = $clog2(HISTORY_DEPTH + 1);
    localparam int CNT_W   = (CNT_RAW > rtst_pkg::COUNT_OUT_W) ? CNT_RAW : rtst_pkg::COUNT_OUT_W;
    localparam int VALUE_W = rtst_pkg::VALUE_W;
    localparam int SLOPE_W = rtst_pkg::SLOPE_W;

    // Sequencer states. SCAN walks the whole history once, oldest first, to
    // count found samples and find the oldest and newest of them. TREND waits
    // for the oldest-to-newest division. WALK and DEV visit the intermediate
    // found samples, oldest first, one division each.
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_TREND  = 7'b0001000,
        ST_WALK   = 7'b0010000,
        ST_DEV    = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } rtst_state_t;

    rtst_state_t                 state_reg, state_next;

    // The history is a shift line; the sequencer reads it through one port.
    logic                        hist_found_reg [HISTORY_DEPTH];
    logic signed [VALUE_W-1:0]   hist_value_reg [HISTORY_DEPTH];

    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [IDX_W-1:0]            oldest_idx_reg, oldest_idx_next;
    logic [IDX_W-1:0]            newest_idx_reg, newest_idx_next;
    logic signed [VALUE_W-1:0]   oldest_val_reg, oldest_val_next;
    logic signed [VALUE_W-1:0]   newest_val_reg, newest_val_next;
    logic signed [SLOPE_W-1:0]   trend_reg, trend_next;
    logic signed [SLOPE_W-1:0]   recent_reg, recent_next;
    logic                        ref_set_reg, ref_set_next;
    logic                        ref_neg_reg, ref_neg_next;
    logic signed [SLOPE_W-1:0]   emit_slope_reg, emit_slope_next;
    rtst_pkg::rtst_rule_t        emit_rule_reg, emit_rule_next;

    logic                        out_valid_reg, out_valid_next;
    rtst_pkg::rtst_out_t         out_reg, out_next;

    logic                        accept;
    logic                        out_free;
    logic                        rd_found;
    logic signed [VALUE_W-1:0]   rd_value;
    logic                        div_start;
    logic signed [rtst_pkg::DIFF_W-1:0] div_diff;
    logic [IDX_W-1:0]            div_dist;
    logic                        div_done;
    logic signed [SLOPE_W-1:0]   div_quot;
    logic                        dev_pos;
    logic                        dev_neg;

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign out_free   = !out_valid_reg || result_ready;

    assign rd_found = hist_found_reg[idx_reg];
    assign rd_value = hist_value_reg[idx_reg];

    // Sign of the deviation of the fresh slope from the trend.
    assign dev_pos = (div_quot > trend_reg);
    assign dev_neg = (div_quot < trend_reg);

    rtst_div #(
        .DIST_W (IDX_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (div_diff),
        .span  (div_dist),
        .done  (div_done),
        .quot  (div_quot)
    );

    // History update: a restart empties it and keeps only the new sample,
    // an update shifts everything one place older and inserts at the front.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_found_reg[i] <= 1'b0;
                hist_value_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            for (int i = 1; i < HISTORY_DEPTH; i++)
            begin
                if (item.req_type == rtst_pkg::REQ_RESTART)
                begin
                    hist_found_reg[i] <= 1'b0;
                    hist_value_reg[i] <= '0;
                end
                else
                begin
                    hist_found_reg[i] <= hist_found_reg[i-1];
                    hist_value_reg[i] <= hist_value_reg[i-1];
                end
            end
            hist_found_reg[0] <= item.sample_found;
            hist_value_reg[0] <= item.sample_value;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        oldest_idx_next = oldest_idx_reg;
        newest_idx_next = newest_idx_reg;
        oldest_val_next = oldest_val_reg;
        newest_val_next = newest_val_reg;
        trend_next      = trend_reg;
        recent_next     = recent_reg;
        ref_set_next    = ref_set_reg;
        ref_neg_next    = ref_neg_reg;
        emit_slope_next = emit_slope_reg;
        emit_rule_next  = emit_rule_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_next        = out_reg;
        div_start       = 1'b0;
        div_diff        = {newest_val_reg[VALUE_W-1], newest_val_reg}
                        - {oldest_val_reg[VALUE_W-1], oldest_val_reg};
        div_dist        = oldest_idx_reg - newest_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.req_type == rtst_pkg::REQ_UPDATE)
                begin
                    idx_next   = IDX_W'(HISTORY_DEPTH - 1);
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // The first found entry seen is the oldest; the last one the newest.
                if (rd_found)
                begin
                    if (cnt_reg == '0)
                    begin
                        oldest_idx_next = idx_reg;
                        oldest_val_next = rd_value;
                    end
                    newest_idx_next = idx_reg;
                    newest_val_next = rd_value;
                    cnt_next        = cnt_reg + 1'b1;
                end
                if (idx_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_DECIDE:
            begin
                if (cnt_reg < CNT_W'(2))
                begin
                    emit_slope_next = '0;
                    emit_rule_next  = rtst_pkg::RULE_FEW;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_TREND;
                end
            end
            ST_TREND:
            begin
                if (div_done)
                begin
                    trend_next   = div_quot;
                    ref_set_next = 1'b0;
                    ref_neg_next = 1'b0;
                    if (cnt_reg == CNT_W'(2))
                    begin
                        emit_slope_next = div_quot;
                        emit_rule_next  = rtst_pkg::RULE_TWO;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        idx_next   = oldest_idx_reg - 1'b1;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                div_diff = {newest_val_reg[VALUE_W-1], newest_val_reg}
                         - {rd_value[VALUE_W-1], rd_value};
                div_dist = idx_reg - newest_idx_reg;
                if (idx_reg == newest_idx_reg)
                begin
                    // Walk finished without a sign change.
                    emit_slope_next = recent_reg;
                    emit_rule_next  = rtst_pkg::RULE_RECENT;
                    state_next      = ST_EMIT;
                end
                else if (rd_found)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DEV;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_DEV:
            begin
                if (div_done)
                begin
                    if (ref_set_reg && ((ref_neg_reg && dev_pos) || (!ref_neg_reg && dev_neg)))
                    begin
                        emit_slope_next = trend_reg;
                        emit_rule_next  = rtst_pkg::RULE_CHANGE;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        // A zero deviation never sets the reference sign.
                        if (!ref_set_reg && (dev_pos || dev_neg))
                        begin
                            ref_set_next = 1'b1;
                            ref_neg_next = dev_neg;
                        end
                        recent_next = div_quot;
                        idx_next    = idx_reg - 1'b1;
                        state_next  = ST_WALK;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.slope      = emit_slope_reg;
                    out_next.slope_rule = emit_rule_reg;
                    out_next.found_count = (cnt_reg > CNT_W'(15)) ? rtst_pkg::COUNT_OUT_W'(15)
                                         : cnt_reg[rtst_pkg::COUNT_OUT_W-1:0];
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            ref_set_reg   <= 1'b0;
            ref_neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            ref_set_reg   <= ref_set_next;
            ref_neg_reg   <= ref_neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oldest_idx_reg <= oldest_idx_next;
        newest_idx_reg <= newest_idx_next;
        oldest_val_reg <= oldest_val_next;
        newest_val_reg <= newest_val_next;
        trend_reg      <= trend_next;
        recent_reg     <= recent_next;
        emit_slope_reg <= emit_slope_next;
        emit_rule_reg  <= emit_rule_next;
        out_reg        <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A result that claims too few samples always carries a zero slope.
    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.slope_rule == rtst_pkg::RULE_FEW |-> result.slope == '0)
        else $error("too-few-samples result with nonzero slope");

    // Any slope rule other than too few samples needs at least two found samples.
    a_rule_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.slope_rule != rtst_pkg::RULE_FEW |-> result.found_count >= 2)
        else $error("slope rule with fewer than two found samples");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_TREND || state_reg == ST_DEV)
        else $error("divider finished outside a waiting state");

    // A restart item returns the block to idle at once.
    a_restart_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.req_type == rtst_pkg::REQ_RESTART |=> state_reg == ST_IDLE)
        else $error("restart item did not leave the block idle");

    // A sign-change result means the walk saw a reference sign first.
    a_change_ref: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && emit_rule_reg == rtst_pkg::RULE_CHANGE |-> ref_set_reg)
        else $error("sign change reported without a reference sign");

endmodule
